### sv/armdp_pkg.sv
`timescale 1ns / 1ps

package armdp_pkg;

    // Data-processing opcodes, instruction bits 24:21
    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_RSC = 4'd7,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } opcode_t;

    // Shift types, instruction bits 6:5
    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } shift_type_t;

    localparam int unsigned WORD_W     = 32;
    localparam logic [3:0]  PC_INDEX   = 4'd15;
    localparam logic [7:0]  AMOUNT_32  = 8'd32;
    localparam int unsigned S_TDATA_W  = 136;
    localparam int unsigned M_TDATA_W  = 48;

    // Second operand and shifter carry-out
    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              carry;
    } shift_res_t;

    // One executed instruction
    typedef struct packed {
        logic              flag_v;
        logic              flag_c;
        logic              flag_z;
        logic              flag_n;
        logic              update_v;
        logic              update_c;
        logic              update_nz;
        logic              write_dest;
        logic [3:0]        dest_index;
        logic [WORD_W-1:0] result_value;
    } alu_res_t;

endpackage

### sv/armdp_shifter.sv
`timescale 1ns / 1ps

module armdp_shifter (
    input  logic [31:0]            instr_word,
    input  logic [31:0]            shifted_value,
    input  logic [31:0]            amount_value,
    input  logic                   carry_in,
    output armdp_pkg::shift_res_t  operand
);

    logic [4:0]              rot;
    logic [63:0]             imm_wide;
    logic [31:0]             imm_val;
    armdp_pkg::shift_type_t  sh_type;
    logic                    is_reg;
    logic [7:0]              amt;
    logic                    is_rrx;
    logic                    sign;
    logic [32:0]             lsl_wide;
    logic [32:0]             lsr_wide;
    logic [32:0]             asr_wide;
    logic [63:0]             ror_wide;
    logic                    amt_small;

    // Rotated 8-bit immediate
    assign rot      = {instr_word[11:8], 1'b0};
    assign imm_wide = {24'd0, instr_word[7:0], 24'd0, instr_word[7:0]} >> rot;
    assign imm_val  = imm_wide[31:0];

    // Decode shift amount; immediate zero selects LSR/ASR by 32 or RRX
    assign sh_type = armdp_pkg::shift_type_t'(instr_word[6:5]);
    assign is_reg  = instr_word[4];
    assign is_rrx  = !is_reg && (instr_word[11:7] == 5'd0) && (sh_type == armdp_pkg::SH_ROR);

    always_comb begin
        if (is_reg) begin
            amt = amount_value[7:0];
        end else if ((instr_word[11:7] == 5'd0) &&
                     (sh_type == armdp_pkg::SH_LSR || sh_type == armdp_pkg::SH_ASR)) begin
            amt = armdp_pkg::AMOUNT_32;
        end else begin
            amt = {3'd0, instr_word[11:7]};
        end
    end

    // Barrel shifts for amounts below 32, carry kept in the extra bit
    assign sign      = shifted_value[31];
    assign amt_small = (amt[7:5] == 3'd0);
    assign lsl_wide  = {1'b0, shifted_value} << amt[4:0];
    assign lsr_wide  = {shifted_value, 1'b0} >> amt[4:0];
    assign asr_wide  = 33'($signed({shifted_value, 1'b0}) >>> amt[4:0]);
    assign ror_wide  = {shifted_value, shifted_value} >> amt[4:0];

    always_comb begin
        operand.value = shifted_value;
        operand.carry = carry_in;
        if (instr_word[25]) begin
            operand.value = imm_val;
            operand.carry = (rot == 5'd0) ? carry_in : imm_val[31];
        end else if (is_rrx) begin
            operand.value = {carry_in, shifted_value[31:1]};
            operand.carry = shifted_value[0];
        end else if (amt != 8'd0) begin
            case (sh_type)
                armdp_pkg::SH_LSL: begin
                    if (amt_small) begin
                        operand.value = lsl_wide[31:0];
                        operand.carry = lsl_wide[32];
                    end else begin
                        operand.value = '0;
                        operand.carry = (amt == armdp_pkg::AMOUNT_32) && shifted_value[0];
                    end
                end
                armdp_pkg::SH_LSR: begin
                    if (amt_small) begin
                        operand.value = lsr_wide[32:1];
                        operand.carry = lsr_wide[0];
                    end else begin
                        operand.value = '0;
                        operand.carry = (amt == armdp_pkg::AMOUNT_32) && sign;
                    end
                end
                armdp_pkg::SH_ASR: begin
                    if (amt_small) begin
                        operand.value = asr_wide[32:1];
                        operand.carry = asr_wide[0];
                    end else begin
                        operand.value = {32{sign}};
                        operand.carry = sign;
                    end
                end
                default: begin
                    // Multiple of 32 keeps the value, carry is the top bit
                    operand.value = ror_wide[31:0];
                    operand.carry = ror_wide[31];
                end
            endcase
        end
    end

endmodule

### sv/armdp_alu.sv
`timescale 1ns / 1ps

module armdp_alu (
    input  logic [31:0]           instr_word,
    input  logic [31:0]           first_value,
    input  logic                  carry_in,
    input  armdp_pkg::shift_res_t operand,
    output armdp_pkg::alu_res_t   res
);

    armdp_pkg::opcode_t opc;
    logic [31:0]        a;
    logic [31:0]        b;
    logic [31:0]        add_x;
    logic [31:0]        add_y;
    logic               add_c;
    logic [32:0]        sum;
    logic [31:0]        logic_res;
    logic [31:0]        value;
    logic               arith;
    logic               upd;
    logic               overflow;

    assign opc = armdp_pkg::opcode_t'(instr_word[24:21]);
    assign a   = first_value;
    assign b   = operand.value;
    assign upd = instr_word[20] && (instr_word[15:12] != armdp_pkg::PC_INDEX);

    // Select adder operands and the logical result
    always_comb begin
        add_x     = a;
        add_y     = b;
        add_c     = 1'b0;
        arith     = 1'b1;
        logic_res = '0;
        case (opc)
            armdp_pkg::OP_SUB, armdp_pkg::OP_CMP: begin
                add_y = ~b;
                add_c = 1'b1;
            end
            armdp_pkg::OP_RSB: begin
                add_x = b;
                add_y = ~a;
                add_c = 1'b1;
            end
            armdp_pkg::OP_ADD, armdp_pkg::OP_CMN: begin
                add_c = 1'b0;
            end
            armdp_pkg::OP_ADC: begin
                add_c = carry_in;
            end
            armdp_pkg::OP_SBC: begin
                add_y = ~b;
                add_c = carry_in;
            end
            armdp_pkg::OP_RSC: begin
                add_x = b;
                add_y = ~a;
                add_c = carry_in;
            end
            armdp_pkg::OP_AND, armdp_pkg::OP_TST: begin
                arith     = 1'b0;
                logic_res = a & b;
            end
            armdp_pkg::OP_EOR, armdp_pkg::OP_TEQ: begin
                arith     = 1'b0;
                logic_res = a ^ b;
            end
            armdp_pkg::OP_ORR: begin
                arith     = 1'b0;
                logic_res = a | b;
            end
            armdp_pkg::OP_MOV: begin
                arith     = 1'b0;
                logic_res = b;
            end
            armdp_pkg::OP_BIC: begin
                arith     = 1'b0;
                logic_res = a & ~b;
            end
            default: begin
                arith     = 1'b0;
                logic_res = ~b;
            end
        endcase
    end

    // Add with carry-in, carry-out and signed overflow
    assign sum      = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_c};
    assign overflow = ((add_x[31] ^ sum[31]) & (add_y[31] ^ sum[31]));
    assign value    = arith ? sum[31:0] : logic_res;

    // Pack result, flags and update masks
    always_comb begin
        res.result_value = value;
        res.dest_index   = instr_word[15:12];
        res.write_dest   = !(opc inside {armdp_pkg::OP_TST, armdp_pkg::OP_TEQ,
                                         armdp_pkg::OP_CMP, armdp_pkg::OP_CMN});
        res.update_nz    = upd || (opc == armdp_pkg::OP_TST) || (opc == armdp_pkg::OP_TEQ);
        res.update_c     = upd;
        res.update_v     = upd && arith;
        res.flag_n       = value[31];
        res.flag_z       = (value == 32'd0);
        res.flag_c       = arith ? sum[32] : operand.carry;
        res.flag_v       = arith && overflow;
    end

endmodule

### sv/arm_data_processing_alu_core.sv
`timescale 1ns / 1ps

// Data-processing execute unit: runs one ARM data-processing instruction
// (all sixteen opcodes, rotated-immediate or shifted-register second operand)
// on the register values delivered with it and returns the result, Rd, a
// write enable, the new N Z C V flags and per-flag update masks. An item is
// captured in an input register, passes combinationally through the shifter
// and ALU and lands in a result register; one item is accepted every cycle
// unless the output stalls, when the result register and a full input
// register both hold their items. Register file, PC and status register
// writes are done by the caller from the masks.
module arm_data_processing_alu_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // instr_word[31:0], first_value[63:32], shifted_value[95:64],
    // amount_value[127:96], carry_in[128], zero pad[135:129]
    input  logic [armdp_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result_value[31:0], dest_index[35:32], write_dest[36], update_nz[37],
    // update_c[38], update_v[39], flag_n[40], flag_z[41], flag_c[42],
    // flag_v[43], zero pad[47:44]
    output logic [armdp_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [31:0]           instr_reg;
    logic [31:0]           first_reg;
    logic [31:0]           shifted_reg;
    logic [31:0]           amount_reg;
    logic                  carry_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    armdp_pkg::alu_res_t   out_reg;
    logic                  out_ready;
    armdp_pkg::shift_res_t operand;
    armdp_pkg::alu_res_t   alu_res;

    // Handshake: each stage takes an item when empty or draining
    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_comb begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = out_ready ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the incoming item
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            instr_reg   <= s_tdata[31:0];
            first_reg   <= s_tdata[63:32];
            shifted_reg <= s_tdata[95:64];
            amount_reg  <= s_tdata[127:96];
            carry_reg   <= s_tdata[128];
        end
    end

    armdp_shifter u_shifter (
        .instr_word    (instr_reg),
        .shifted_value (shifted_reg),
        .amount_value  (amount_reg),
        .carry_in      (carry_reg),
        .operand       (operand)
    );

    armdp_alu u_alu (
        .instr_word  (instr_reg),
        .first_value (first_reg),
        .carry_in    (carry_reg),
        .operand     (operand),
        .res         (alu_res)
    );

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (in_valid_reg && out_ready) begin
            out_reg <= alu_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg};

endmodule
